// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define VBAS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Same-cycle implication.
`define VBAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VBAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/vbas_pkg.sv =====
// Types and constants of the vector beam analog section.
`default_nettype none

package vbas_pkg;

    typedef enum logic [2:0] {
        MODE_WR_A  = 3'd0,
        MODE_WR_B  = 3'd1,
        MODE_CA2   = 3'd2,
        MODE_TICK  = 3'd3,
        MODE_RD_A  = 3'd4,
        MODE_RD_B  = 3'd5,
        MODE_FLUSH = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_SND_DATA = 2'd1,
        KIND_SND_ADDR = 2'd2,
        KIND_SEGMENT  = 2'd3
    } kind_t;

    // Port B bits 4:3 steer the sound chip bus
    localparam logic [1:0] BUS_PSG_RD = 2'b01;
    localparam logic [1:0] BUS_DATA   = 2'b10;
    localparam logic [1:0] BUS_ADDR   = 2'b11;

    // Port B bits 2:1 pick the sample-and-hold and pot channel
    localparam logic [1:0] MUX_Y   = 2'b00;
    localparam logic [1:0] MUX_REF = 2'b01;
    localparam logic [1:0] MUX_Z   = 2'b10;

    localparam logic [3:0] SND_REG_IO  = 4'd14;
    localparam logic [7:0] DAC_FLIP    = 8'h80;
    localparam logic [7:0] POT_CENTRE  = 8'h80;
    localparam logic [7:0] HOLD_CENTRE = 8'h80;

    typedef struct packed {
        mode_t             mode;
        logic [7:0]        value;
        logic signed [7:0] joy_x;
        logic signed [7:0] joy_y;
        logic [7:0]        psg_read_data;
        logic              t1_owns_pb7;
        logic              t1_pb7_level;
        logic              blank_from_shift;
        logic              shift_cb2_level;
        logic              handshake_cb2_level;
    } item_t;

    // Result from the port side (reads and sound bus beats)
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
    } port_res_t;

    // Analog state the integrator needs
    typedef struct packed {
        logic              zero_on;
        logic              pb7;
        logic [6:0]        z_hold;
        logic signed [8:0] rate_x;
        logic signed [8:0] rate_y;
    } analog_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector_beam_analog_section_top.sv =====
// Top level of the vector beam analog section: input register, result register.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+------------
//  s_axis   | in  | value, joy_x, joy_y, psg_read_data, flags| mode (3)
//  m_axis   | out | data, seg_x0/y0/x1/y1, seg_intensity     | kind (2)
//
// One beat accepted per clock unless a stalled result and a full input register hold s_tready low.
// A beat passes through the input register and then the result register; the state update
// (beam add, saturate, screen compare) sits between them.
// Reset clears the latches, the Z hold and the beam, sets the other holds to centre, and drops any held item.
// A stalled result holds m_axis; the input register still takes one more beat.
`default_nettype none

module vector_beam_analog_section_top #(
    parameter int HALF_WIDTH  = 16500,
    parameter int HALF_HEIGHT = 20500,
    parameter int POS_BITS    = 24,
    localparam int OUT_BITS   = 8 + 4 * POS_BITS + 7,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // value[7:0], joy_x[15:8], joy_y[23:16], psg_read_data[31:24], t1_owns_pb7[32],
    // t1_pb7_level[33], blank_from_shift[34], shift_cb2_level[35],
    // handshake_cb2_level[36], zero pad
    input  wire logic [39:0]      s_tdata,
    // mode[2:0]
    input  wire logic [2:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // data[7:0], seg_x0, seg_y0, seg_x1, seg_y1 (POS_BITS each), seg_intensity[6:0],
    // zero pad
    output logic [OUT_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]            m_tuser
);

`include "assert_macros.svh"

    vbas_pkg::item_t     item_reg;
    logic                in_vld_reg, in_vld_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_free, fire, s_beat;

    vbas_pkg::port_res_t port_res;
    vbas_pkg::analog_t   analog;
    logic                seg_vld;
    logic signed [POS_BITS-1:0] seg_x0, seg_y0, seg_x1, seg_y1;
    logic [6:0]          seg_z;

    vbas_pkg::kind_t            kind_reg;
    logic [7:0]                 data_reg;
    logic signed [POS_BITS-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [6:0]                 z_reg;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_beat   = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_beat)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (fire)
        begin
            out_vld_next = port_res.valid || seg_vld;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            item_reg.mode                <= vbas_pkg::mode_t'(s_tuser);
            item_reg.value               <= s_tdata[7:0];
            item_reg.joy_x               <= s_tdata[15:8];
            item_reg.joy_y               <= s_tdata[23:16];
            item_reg.psg_read_data       <= s_tdata[31:24];
            item_reg.t1_owns_pb7         <= s_tdata[32];
            item_reg.t1_pb7_level        <= s_tdata[33];
            item_reg.blank_from_shift    <= s_tdata[34];
            item_reg.shift_cb2_level     <= s_tdata[35];
            item_reg.handshake_cb2_level <= s_tdata[36];
        end
    end

    vbas_ports u_ports (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .port_res (port_res),
        .analog   (analog)
    );

    vbas_beam #(
        .HALF_WIDTH  (HALF_WIDTH),
        .HALF_HEIGHT (HALF_HEIGHT),
        .POS_BITS    (POS_BITS)
    ) u_beam (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item_reg),
        .analog  (analog),
        .seg_vld (seg_vld),
        .seg_x0  (seg_x0),
        .seg_y0  (seg_y0),
        .seg_x1  (seg_x1),
        .seg_y1  (seg_y1),
        .seg_z   (seg_z)
    );

    // result payload; unused fields of a beat read as zero
    always_ff @(posedge clk)
    begin
        if (fire && seg_vld)
        begin
            kind_reg <= vbas_pkg::KIND_SEGMENT;
            data_reg <= '0;
            x0_reg   <= seg_x0;
            y0_reg   <= seg_y0;
            x1_reg   <= seg_x1;
            y1_reg   <= seg_y1;
            z_reg    <= seg_z;
        end
        else if (fire && port_res.valid)
        begin
            kind_reg <= port_res.kind;
            data_reg <= port_res.data;
            x0_reg   <= '0;
            y0_reg   <= '0;
            x1_reg   <= '0;
            y1_reg   <= '0;
            z_reg    <= '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, z_reg, y1_reg, x1_reg, y0_reg, x0_reg,
                       data_reg};

    `VBAS_ASSERT_NEVER(a_one_source, clk, rst_n, port_res.valid && seg_vld, "two result sources at once")
    `VBAS_ASSERT_IMPLY(a_seg_only_tick_flush, clk, rst_n, in_vld_reg && (item_reg.mode != vbas_pkg::MODE_TICK) && (item_reg.mode != vbas_pkg::MODE_FLUSH), !seg_vld, "segment from a non-beam item")
    `VBAS_ASSERT_NEXT(a_result_lands, clk, rst_n, fire && (port_res.valid || seg_vld), m_tvalid, "result not presented")
    `VBAS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, in_vld_reg && m_tvalid && !m_tready, "input stalled without a full pipeline")

endmodule

`default_nettype wire

// ===== rtl/core/vbas_ports.sv =====
// Port latches, sample-and-holds, sound bus and port reads.
`default_nettype none

module vbas_ports (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire vbas_pkg::item_t    item,
    output vbas_pkg::port_res_t     port_res,
    output vbas_pkg::analog_t       analog
);

    logic [7:0]        pa_reg, pa_next;
    logic [7:0]        pb_reg, pb_next;
    logic [7:0]        xh_reg, xh_next;
    logic [7:0]        ref_reg, ref_next;
    logic [7:0]        yh_reg, yh_next;
    logic [6:0]        zh_reg, zh_next;
    logic [7:0]        pot_reg, pot_next;
    logic signed [8:0] rate_x_reg, rate_x_next;
    logic signed [8:0] rate_y_reg, rate_y_next;
    logic [3:0]        sel_reg, sel_next;
    logic              zero_reg, zero_next;

    logic [7:0] pa_eff, pb_eff, xh_eff, rd_b;

    always_comb
    begin
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        xh_next     = xh_reg;
        ref_next    = ref_reg;
        yh_next     = yh_reg;
        zh_next     = zh_reg;
        pot_next    = pot_reg;
        rate_x_next = rate_x_reg;
        rate_y_next = rate_y_reg;
        sel_next    = sel_reg;
        zero_next   = zero_reg;
        port_res    = '0;

        pa_eff = (item.mode == vbas_pkg::MODE_WR_A) ? item.value : pa_reg;
        pb_eff = (item.mode == vbas_pkg::MODE_WR_B) ? item.value : pb_reg;
        xh_eff = (item.mode == vbas_pkg::MODE_WR_A) ? (item.value ^ vbas_pkg::DAC_FLIP)
                                                    : xh_reg;

        rd_b = pb_reg;
        if (item.t1_owns_pb7)
        begin
            rd_b[7] = item.t1_pb7_level;
        end
        rd_b[5] = (pot_reg > xh_reg);

        unique case (item.mode)
            vbas_pkg::MODE_WR_A, vbas_pkg::MODE_WR_B:
            begin
                pa_next = pa_eff;
                pb_next = pb_eff;
                xh_next = xh_eff;

                // sound chip bus, using the freshly written latches
                unique case (pb_eff[4:3])
                    vbas_pkg::BUS_DATA:
                    begin
                        if (sel_reg != vbas_pkg::SND_REG_IO)
                        begin
                            port_res = '{1'b1, vbas_pkg::KIND_SND_DATA, pa_eff};
                        end
                    end
                    vbas_pkg::BUS_ADDR:
                    begin
                        if (pa_eff[7:4] == 4'h0)
                        begin
                            sel_next = pa_eff[3:0];
                            port_res = '{1'b1, vbas_pkg::KIND_SND_ADDR, pa_eff};
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // multiplexer; bit 0 low enables the hold update
                unique case (pb_eff[2:1])
                    vbas_pkg::MUX_Y:
                    begin
                        pot_next = item.joy_x ^ vbas_pkg::POT_CENTRE;
                        if (!pb_eff[0])
                        begin
                            yh_next = xh_eff;
                        end
                    end
                    vbas_pkg::MUX_REF:
                    begin
                        pot_next = item.joy_y ^ vbas_pkg::POT_CENTRE;
                        if (!pb_eff[0])
                        begin
                            ref_next = xh_eff;
                        end
                    end
                    vbas_pkg::MUX_Z:
                    begin
                        pot_next = vbas_pkg::POT_CENTRE;
                        if (!pb_eff[0])
                        begin
                            zh_next = xh_eff[7] ? xh_eff[6:0] : 7'd0;
                        end
                    end
                    default:
                    begin
                        pot_next = vbas_pkg::POT_CENTRE;
                    end
                endcase

                rate_x_next = $signed({1'b0, xh_eff}) - $signed({1'b0, ref_next});
                rate_y_next = $signed({1'b0, ref_next}) - $signed({1'b0, yh_next});
            end
            vbas_pkg::MODE_CA2:
            begin
                zero_next = !item.value[0];
            end
            vbas_pkg::MODE_RD_A:
            begin
                port_res = '{1'b1, vbas_pkg::KIND_READ,
                             (pb_reg[4:3] == vbas_pkg::BUS_PSG_RD) ? item.psg_read_data
                                                                   : pa_reg};
            end
            vbas_pkg::MODE_RD_B:
            begin
                port_res = '{1'b1, vbas_pkg::KIND_READ, rd_b};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg     <= '0;
            pb_reg     <= '0;
            xh_reg     <= vbas_pkg::HOLD_CENTRE;
            ref_reg    <= vbas_pkg::HOLD_CENTRE;
            yh_reg     <= vbas_pkg::HOLD_CENTRE;
            zh_reg     <= '0;
            pot_reg    <= vbas_pkg::POT_CENTRE;
            rate_x_reg <= '0;
            rate_y_reg <= '0;
            sel_reg    <= '0;
            zero_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            xh_reg     <= xh_next;
            ref_reg    <= ref_next;
            yh_reg     <= yh_next;
            zh_reg     <= zh_next;
            pot_reg    <= pot_next;
            rate_x_reg <= rate_x_next;
            rate_y_reg <= rate_y_next;
            sel_reg    <= sel_next;
            zero_reg   <= zero_next;
        end
    end

    assign analog = '{zero_reg, pb_reg[7], zh_reg, rate_x_reg, rate_y_reg};

endmodule

`default_nettype wire

// ===== rtl/core/vbas_beam.sv =====
// Beam integrator and line segment tracker.
`default_nettype none

module vbas_beam #(
    parameter int HALF_WIDTH  = 16500,
    parameter int HALF_HEIGHT = 20500,
    parameter int POS_BITS    = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire vbas_pkg::item_t            item,
    input  wire vbas_pkg::analog_t          analog,
    output logic                            seg_vld,
    output logic signed [POS_BITS-1:0]      seg_x0,
    output logic signed [POS_BITS-1:0]      seg_y0,
    output logic signed [POS_BITS-1:0]      seg_x1,
    output logic signed [POS_BITS-1:0]      seg_y1,
    output logic [6:0]                      seg_z
);

    localparam int CMP_W = (POS_BITS > 23) ? POS_BITS + 1 : 24;
    localparam logic signed [CMP_W-1:0] HW = CMP_W'(HALF_WIDTH);
    localparam logic signed [CMP_W-1:0] HH = CMP_W'(HALF_HEIGHT);

    logic signed [POS_BITS-1:0] beam_x_reg, beam_x_next, beam_y_reg, beam_y_next;
    logic signed [POS_BITS-1:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic signed [POS_BITS-1:0] end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic signed [POS_BITS:0]   seg_rate_x_reg, seg_rate_x_next;
    logic signed [POS_BITS:0]   seg_rate_y_reg, seg_rate_y_next;
    logic [6:0]                 seg_z_reg, seg_z_next;
    logic                       drawing_reg, drawing_next;

    logic signed [POS_BITS:0]   sdx, sdy;
    logic signed [POS_BITS+1:0] sum_x, sum_y;
    logic signed [POS_BITS-1:0] new_x, new_y;
    logic                       unblanked, ramp, on_now, on_new;

    function automatic logic in_view(input logic signed [POS_BITS-1:0] x,
                                     input logic signed [POS_BITS-1:0] y);
        logic signed [CMP_W-1:0] xe;
        logic signed [CMP_W-1:0] ye;
        xe = CMP_W'(x);
        ye = CMP_W'(y);
        return (xe > -HW) && (xe < HW) && (ye > -HH) && (ye < HH);
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat(input logic signed [POS_BITS+1:0] s);
        logic signed [POS_BITS-1:0] r;
        // top three bits agree: value fits
        if ((s[POS_BITS+1:POS_BITS-1] == 3'b000) || (s[POS_BITS+1:POS_BITS-1] == 3'b111))
        begin
            r = s[POS_BITS-1:0];
        end
        else if (s[POS_BITS+1])
        begin
            r = {1'b1, {(POS_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb
    begin
        unblanked = item.blank_from_shift ? item.shift_cb2_level : item.handshake_cb2_level;
        ramp      = item.t1_owns_pb7 ? item.t1_pb7_level : analog.pb7;

        // under ZERO the step pulls the beam straight back to the origin
        if (analog.zero_on)
        begin
            sdx = -{beam_x_reg[POS_BITS-1], beam_x_reg};
            sdy = -{beam_y_reg[POS_BITS-1], beam_y_reg};
        end
        else if (ramp)
        begin
            sdx = '0;
            sdy = '0;
        end
        else
        begin
            sdx = (POS_BITS+1)'(analog.rate_x);
            sdy = (POS_BITS+1)'(analog.rate_y);
        end

        sum_x  = (POS_BITS+2)'(beam_x_reg) + (POS_BITS+2)'(sdx);
        sum_y  = (POS_BITS+2)'(beam_y_reg) + (POS_BITS+2)'(sdy);
        new_x  = sat(sum_x);
        new_y  = sat(sum_y);
        on_now = in_view(beam_x_reg, beam_y_reg);
        on_new = in_view(new_x, new_y);

        beam_x_next     = beam_x_reg;
        beam_y_next     = beam_y_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        seg_rate_x_next = seg_rate_x_reg;
        seg_rate_y_next = seg_rate_y_reg;
        seg_z_next      = seg_z_reg;
        drawing_next    = drawing_reg;
        seg_vld         = 1'b0;

        if (item.mode == vbas_pkg::MODE_TICK)
        begin
            if (!drawing_reg)
            begin
                if (unblanked && on_now)
                begin
                    drawing_next    = 1'b1;
                    start_x_next    = beam_x_reg;
                    start_y_next    = beam_y_reg;
                    end_x_next      = beam_x_reg;
                    end_y_next      = beam_y_reg;
                    seg_rate_x_next = sdx;
                    seg_rate_y_next = sdy;
                    seg_z_next      = analog.z_hold;
                end
            end
            else if (!unblanked)
            begin
                seg_vld      = 1'b1;
                drawing_next = 1'b0;
            end
            else if ((sdx != seg_rate_x_reg) || (sdy != seg_rate_y_reg) ||
                     (analog.z_hold != seg_z_reg))
            begin
                // rate or intensity change closes the segment; restart if on screen
                seg_vld = 1'b1;
                if (on_now)
                begin
                    start_x_next    = beam_x_reg;
                    start_y_next    = beam_y_reg;
                    end_x_next      = beam_x_reg;
                    end_y_next      = beam_y_reg;
                    seg_rate_x_next = sdx;
                    seg_rate_y_next = sdy;
                    seg_z_next      = analog.z_hold;
                end
                else
                begin
                    drawing_next = 1'b0;
                end
            end

            beam_x_next = new_x;
            beam_y_next = new_y;
            if (drawing_next && on_new)
            begin
                end_x_next = new_x;
                end_y_next = new_y;
            end
        end
        else if ((item.mode == vbas_pkg::MODE_FLUSH) && drawing_reg)
        begin
            seg_vld      = 1'b1;
            start_x_next = end_x_reg;
            start_y_next = end_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_x_reg     <= '0;
            beam_y_reg     <= '0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            seg_rate_x_reg <= '0;
            seg_rate_y_reg <= '0;
            seg_z_reg      <= '0;
            drawing_reg    <= 1'b0;
        end
        else if (fire)
        begin
            beam_x_reg     <= beam_x_next;
            beam_y_reg     <= beam_y_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            seg_rate_x_reg <= seg_rate_x_next;
            seg_rate_y_reg <= seg_rate_y_next;
            seg_z_reg      <= seg_z_next;
            drawing_reg    <= drawing_next;
        end
    end

    assign seg_x0 = start_x_reg;
    assign seg_y0 = start_y_reg;
    assign seg_x1 = end_x_reg;
    assign seg_y1 = end_y_reg;
    assign seg_z  = seg_z_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_vector_beam_analog_section_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the vector beam analog section: directed, ramp and random runs.
module tb_vector_beam_analog_section_top;

    localparam int POS_W  = 24;
    localparam int HALF_W = 16500;
    localparam int HALF_H = 20500;
    localparam int RES_W  = ((8 + 4 * POS_W + 7 + 7) / 8) * 8;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [1:0] MUX_SPARE   = 2'b11;

    localparam int RANDOM_ITEMS  = 900;
    localparam int CLIMB_TICKS   = 160;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        vbas_pkg::kind_t  kind;
        logic [7:0]       data;
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] y0;
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y1;
        logic [6:0]       bright;
    } console_out_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata  = '0;
    logic [2:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent_items = 0;
    int fails = 0;
    int beats_of_kind [4] = '{0, 0, 0, 0};

    console_out_t results_due [$];

    // Shadow of the board state
    logic [7:0] lat_a    = 8'h00;
    logic [7:0] lat_b    = 8'h00;
    logic [7:0] dac_x    = vbas_pkg::HOLD_CENTRE;
    logic [7:0] hold_ref = vbas_pkg::HOLD_CENTRE;
    logic [7:0] hold_y   = vbas_pkg::HOLD_CENTRE;
    logic [7:0] pot_val  = vbas_pkg::POT_CENTRE;
    logic [6:0] hold_z   = 7'd0;
    logic [6:0] seg_bright = 7'd0;
    logic [3:0] snd_reg  = 4'd0;
    bit         zeroing  = 1'b0;
    bit         pen_down = 1'b0;
    longint     slope_x = 0, slope_y = 0;
    longint     pos_x = 0, pos_y = 0;
    longint     seg_sx = 0, seg_sy = 0, seg_ex = 0, seg_ey = 0;
    longint     seg_slope_x = 0, seg_slope_y = 0;

    vector_beam_analog_section_top #(
        .HALF_WIDTH  (HALF_W),
        .HALF_HEIGHT (HALF_H),
        .POS_BITS    (POS_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic bit in_view(longint x, longint y);
        return x > -HALF_W && x < HALF_W && y > -HALF_H && y < HALF_H;
    endfunction

    function automatic longint clamp_pos(longint v);
        longint hi;
        hi = (longint'(1) <<< (POS_W - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic console_out_t segment_beat();
        console_out_t r;
        r        = '0;
        r.kind   = vbas_pkg::KIND_SEGMENT;
        r.x0     = seg_sx[POS_W-1:0];
        r.y0     = seg_sy[POS_W-1:0];
        r.x1     = seg_ex[POS_W-1:0];
        r.y1     = seg_ey[POS_W-1:0];
        r.bright = seg_bright;
        return r;
    endfunction

    function automatic void start_segment(longint dx, longint dy);
        seg_sx      = pos_x;
        seg_ex      = pos_x;
        seg_sy      = pos_y;
        seg_ey      = pos_y;
        seg_slope_x = dx;
        seg_slope_y = dy;
        seg_bright  = hold_z;
    endfunction

    function automatic bit drive_sound_bus(output console_out_t r);
        r = '0;
        case (lat_b[4:3])
            vbas_pkg::BUS_DATA:
                if (snd_reg != vbas_pkg::SND_REG_IO)
                begin
                    r.kind = vbas_pkg::KIND_SND_DATA;
                    r.data = lat_a;
                    return 1'b1;
                end
            vbas_pkg::BUS_ADDR:
                if (lat_a[7:4] == 4'h0)
                begin
                    snd_reg = lat_a[3:0];
                    r.kind  = vbas_pkg::KIND_SND_ADDR;
                    r.data  = lat_a;
                    return 1'b1;
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void steer_mux(logic [7:0] jx, logic [7:0] jy);
        // centre plus deflection, mod 256, is the deflection with its top bit flipped
        case (lat_b[2:1])
            vbas_pkg::MUX_Y:
            begin
                pot_val = jx ^ vbas_pkg::POT_CENTRE;
                if (!lat_b[0])
                    hold_y = dac_x;
            end
            vbas_pkg::MUX_REF:
            begin
                pot_val = jy ^ vbas_pkg::POT_CENTRE;
                if (!lat_b[0])
                    hold_ref = dac_x;
            end
            vbas_pkg::MUX_Z:
            begin
                pot_val = vbas_pkg::POT_CENTRE;
                if (!lat_b[0])
                    hold_z = (dac_x > vbas_pkg::HOLD_CENTRE) ?
                             7'(dac_x - vbas_pkg::HOLD_CENTRE) : 7'd0;
            end
            default: pot_val = vbas_pkg::POT_CENTRE;
        endcase
        slope_x = longint'(dac_x) - longint'(hold_ref);
        slope_y = longint'(hold_ref) - longint'(hold_y);
    endfunction

    task automatic predict_item(input vbas_pkg::item_t it);
        console_out_t r;
        bit           got;
        bit           lit;
        bit           ramp;
        longint       dx;
        longint       dy;
        logic [7:0]   v;
        r   = '0;
        got = 1'b0;
        case (it.mode)
            vbas_pkg::MODE_WR_A:
            begin
                lat_a = it.value;
                dac_x = it.value ^ vbas_pkg::DAC_FLIP;
                got   = drive_sound_bus(r);
                steer_mux(it.joy_x, it.joy_y);
            end
            vbas_pkg::MODE_WR_B:
            begin
                lat_b = it.value;
                got   = drive_sound_bus(r);
                steer_mux(it.joy_x, it.joy_y);
            end
            vbas_pkg::MODE_CA2: zeroing = !it.value[0];
            vbas_pkg::MODE_TICK:
            begin
                lit = it.blank_from_shift ? it.shift_cb2_level : it.handshake_cb2_level;
                dx  = 0;
                dy  = 0;
                if (zeroing)
                begin
                    dx = -pos_x;
                    dy = -pos_y;
                end
                else
                begin
                    ramp = it.t1_owns_pb7 ? it.t1_pb7_level : lat_b[7];
                    if (!ramp)
                    begin
                        dx = slope_x;
                        dy = slope_y;
                    end
                end
                if (!pen_down)
                begin
                    if (lit && in_view(pos_x, pos_y))
                    begin
                        pen_down = 1'b1;
                        start_segment(dx, dy);
                    end
                end
                else if (!lit)
                begin
                    r        = segment_beat();
                    got      = 1'b1;
                    pen_down = 1'b0;
                end
                else if (dx != seg_slope_x || dy != seg_slope_y || hold_z != seg_bright)
                begin
                    r   = segment_beat();
                    got = 1'b1;
                    if (in_view(pos_x, pos_y))
                        start_segment(dx, dy);
                    else
                        pen_down = 1'b0;
                end
                pos_x = clamp_pos(pos_x + dx);
                pos_y = clamp_pos(pos_y + dy);
                if (pen_down && in_view(pos_x, pos_y))
                begin
                    seg_ex = pos_x;
                    seg_ey = pos_y;
                end
            end
            vbas_pkg::MODE_RD_A:
            begin
                r.kind = vbas_pkg::KIND_READ;
                r.data = (lat_b[4:3] == vbas_pkg::BUS_PSG_RD) ? it.psg_read_data : lat_a;
                got    = 1'b1;
            end
            vbas_pkg::MODE_RD_B:
            begin
                v = lat_b;
                if (it.t1_owns_pb7)
                    v[7] = it.t1_pb7_level;
                v[5]   = (pot_val > dac_x);
                r.kind = vbas_pkg::KIND_READ;
                r.data = v;
                got    = 1'b1;
            end
            vbas_pkg::MODE_FLUSH:
                if (pen_down)
                begin
                    r      = segment_beat();
                    got    = 1'b1;
                    seg_sx = seg_ex;
                    seg_sy = seg_ey;
                end
            default: ;
        endcase
        if (got)
            results_due.insert(results_due.size(), r);
    endtask

    function automatic vbas_pkg::item_t any_item(vbas_pkg::mode_t md, logic [7:0] val);
        logic [63:0]     noise;
        vbas_pkg::item_t it;
        noise    = {$urandom, $urandom};
        it       = noise[$bits(vbas_pkg::item_t)-1:0];
        it.mode  = md;
        it.value = val;
        return it;
    endfunction

    // Tick with the chosen unblank level on whichever source drives CB2
    function automatic vbas_pkg::item_t tick_item(bit lit);
        vbas_pkg::item_t it;
        it = any_item(vbas_pkg::MODE_TICK, 8'($urandom));
        if ($urandom_range(7) != 0)
            it.t1_owns_pb7 = 1'b0;
        if (it.blank_from_shift)
            it.shift_cb2_level = lit;
        else
            it.handshake_cb2_level = lit;
        return it;
    endfunction

    task automatic send_item(input vbas_pkg::item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {3'b000, it.handshake_cb2_level, it.shift_cb2_level, it.blank_from_shift,
                     it.t1_pb7_level, it.t1_owns_pb7, it.psg_read_data, it.joy_y, it.joy_x,
                     it.value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(it);
        if (it.mode != MODE_UNUSED)
            sent_items++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [POS_W-1:0] want,
                                        logic [POS_W-1:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %h, got %h", name, want, seen);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        console_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_of_kind[m_tuser]++;
            if (results_due.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d data %h",
                       m_tuser, m_tdata[7:0]);
                fails++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("data", want.data, m_tdata[7:0]);
                check_field("seg_x0", want.x0, m_tdata[8 +: POS_W]);
                check_field("seg_y0", want.y0, m_tdata[8 + POS_W +: POS_W]);
                check_field("seg_x1", want.x1, m_tdata[8 + 2 * POS_W +: POS_W]);
                check_field("seg_y1", want.y1, m_tdata[8 + 3 * POS_W +: POS_W]);
                check_field("seg_intensity", want.bright, m_tdata[8 + 4 * POS_W +: 7]);
            end
        end
    end

    task automatic test_ports_and_sound();
        vbas_pkg::item_t it;
        send_item(any_item(vbas_pkg::MODE_RD_A, 8'h00));
        send_item(any_item(vbas_pkg::MODE_WR_A, {4'h0, vbas_pkg::SND_REG_IO}));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, vbas_pkg::BUS_ADDR, 3'b000}));
        // register 14 selected: data writes stay off the bus
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, vbas_pkg::BUS_DATA, 3'b000}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'hf3));
        // address with high nibble set is dropped
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, vbas_pkg::BUS_ADDR, 3'b000}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'h05));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, vbas_pkg::BUS_DATA, 3'b000}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'hff));
        it = any_item(vbas_pkg::MODE_WR_B,
                      {3'b000, vbas_pkg::BUS_PSG_RD, vbas_pkg::MUX_Y, 1'b0});
        it.joy_x = -8'sd128;
        send_item(it);
        send_item(any_item(vbas_pkg::MODE_RD_A, 8'h00));
        it = any_item(vbas_pkg::MODE_RD_B, 8'h00);
        it.t1_owns_pb7  = 1'b1;
        it.t1_pb7_level = 1'b1;
        send_item(it);
        it = any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, vbas_pkg::MUX_REF, 1'b0});
        it.joy_y = 8'sd127;
        send_item(it);
        send_item(any_item(vbas_pkg::MODE_RD_B, 8'h00));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, vbas_pkg::MUX_Z, 1'b0}));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, MUX_SPARE, 1'b1}));
        send_item(any_item(vbas_pkg::MODE_RD_B, 8'h00));
        send_item(any_item(vbas_pkg::mode_t'(MODE_UNUSED), 8'hff));
    endtask

    task automatic test_segments();
        send_item(any_item(vbas_pkg::MODE_FLUSH, 8'h00));
        send_item(any_item(vbas_pkg::MODE_CA2, 8'h00));
        send_item(tick_item(1'b1));
        send_item(any_item(vbas_pkg::MODE_CA2, 8'h01));
        send_item(any_item(vbas_pkg::MODE_WR_B, 8'h01));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'hff));
        send_item(tick_item(1'b1));
        send_item(tick_item(1'b1));
        send_item(tick_item(1'b1));
        send_item(any_item(vbas_pkg::MODE_FLUSH, 8'h00));
        send_item(tick_item(1'b1));
        send_item(tick_item(1'b0));
        send_item(any_item(vbas_pkg::MODE_WR_B, 8'h81));
        send_item(tick_item(1'b0));
    endtask

    // Full-rate ramp carrying the beam well past the screen edges
    task automatic test_long_ramp();
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, vbas_pkg::MUX_REF, 1'b0}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'h80));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, vbas_pkg::MUX_Y, 1'b0}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'h7f));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'b000, 2'b00, vbas_pkg::MUX_Y, 1'b1}));
        send_item(any_item(vbas_pkg::MODE_CA2, 8'h01));
        repeat (CLIMB_TICKS) send_item(tick_item(1'b0));
        repeat (3) send_item(tick_item(1'b1));
        send_item(any_item(vbas_pkg::MODE_RD_B, 8'h00));
        send_item(any_item(vbas_pkg::MODE_CA2, 8'h00));
        send_item(tick_item(1'b1));
        send_item(tick_item(1'b1));
        send_item(tick_item(1'b0));
        send_item(any_item(vbas_pkg::MODE_CA2, 8'h01));
    endtask

    task automatic run_vector();
        int n;
        send_item(any_item(vbas_pkg::MODE_CA2, {7'($urandom), 1'b0}));
        repeat ($urandom_range(1, 3)) send_item(tick_item($urandom_range(1)));
        send_item(any_item(vbas_pkg::MODE_CA2, {7'($urandom), 1'b1}));
        if ($urandom_range(3) == 0)
        begin
            send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
            send_item(any_item(vbas_pkg::MODE_WR_B,
                               {1'b1, 2'($urandom), 2'b00, vbas_pkg::MUX_REF, 1'b0}));
        end
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {1'b1, 2'($urandom), 2'b00, vbas_pkg::MUX_Y, 1'b0}));
        if ($urandom_range(1) == 1)
        begin
            send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
            send_item(any_item(vbas_pkg::MODE_WR_B,
                               {1'b1, 2'($urandom), 2'b00, vbas_pkg::MUX_Z, 1'b0}));
        end
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {1'b1, 2'($urandom), 2'b00, 2'($urandom), 1'b1}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {1'b0, 2'($urandom), 2'b00, 2'($urandom), 1'b1}));
        n = ($urandom_range(7) == 0) ? $urandom_range(60, 160) : $urandom_range(1, 30);
        repeat (n)
        begin
            case ($urandom_range(19))
                0:       send_item(any_item(vbas_pkg::MODE_FLUSH, 8'($urandom)));
                1:       send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
                2:       send_item(tick_item(1'b0));
                default: send_item(tick_item(1'b1));
            endcase
        end
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {1'b1, 2'($urandom), 2'b00, 2'($urandom), 1'b1}));
        send_item(tick_item(1'b0));
    endtask

    task automatic run_sound_bus();
        logic [7:0] sel;
        sel = {4'h0, ($urandom_range(3) == 0) ? vbas_pkg::SND_REG_IO : 4'($urandom)};
        if ($urandom_range(4) == 0)
            sel[7:4] = 4'($urandom);
        send_item(any_item(vbas_pkg::MODE_WR_A, sel));
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {3'($urandom), vbas_pkg::BUS_ADDR, 3'($urandom)}));
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {3'($urandom), vbas_pkg::BUS_DATA, 3'($urandom)}));
        send_item(any_item(vbas_pkg::MODE_WR_A, 8'($urandom)));
        send_item(any_item(vbas_pkg::MODE_WR_B,
                           {3'($urandom), vbas_pkg::BUS_PSG_RD, 3'($urandom)}));
        send_item(any_item(vbas_pkg::MODE_RD_A, 8'($urandom)));
        send_item(any_item(vbas_pkg::MODE_RD_B, 8'($urandom)));
        send_item(any_item(vbas_pkg::MODE_WR_B, {3'($urandom), 2'b00, 3'($urandom)}));
        send_item(any_item(vbas_pkg::MODE_RD_A, 8'($urandom)));
    endtask

    task automatic test_random();
        int first;
        int done;
        first = sent_items;
        done  = 0;
        while (done < RANDOM_ITEMS)
        begin
            case (done * 4 / RANDOM_ITEMS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: run_vector();
                6, 7:             run_sound_bus();
                default:
                    repeat ($urandom_range(1, 8))
                        send_item(any_item(vbas_pkg::mode_t'(3'($urandom)), 8'($urandom)));
            endcase
            done = sent_items - first;
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ports_and_sound();
        wait_results_done();
        test_segments();
        wait_results_done();
        test_long_ramp();
        wait_results_done();
        test_random();
        wait_results_done();
        $display("Ran %0d beats: port and sound-bus cases, segments, off-screen ramp, %s",
                 sent_items, "random vectors.");
        $display("Results seen: %0d reads, %0d sound writes, %0d address latches, %0d segments.",
                 beats_of_kind[vbas_pkg::KIND_READ], beats_of_kind[vbas_pkg::KIND_SND_DATA],
                 beats_of_kind[vbas_pkg::KIND_SND_ADDR], beats_of_kind[vbas_pkg::KIND_SEGMENT]);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #800_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vbas_pkg.sv
rtl/core/vbas_ports.sv
rtl/core/vbas_beam.sv
rtl/core/vector_beam_analog_section_top.sv
tb/sv/tb_vector_beam_analog_section_top.sv
